/* rtl/sxl_pkg.sv */
package sxl_pkg;

  // Characters the lexer tells apart.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DIG_LO = 8'd48;
  localparam logic [7:0] CH_DIG_HI = 8'd57;
  localparam logic [7:0] CH_UC_LO  = 8'd65;
  localparam logic [7:0] CH_UC_HI  = 8'd90;
  localparam logic [7:0] CH_LC_LO  = 8'd97;
  localparam logic [7:0] CH_LC_HI  = 8'd122;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    TK_TEXT  = 2'd0,
    TK_OPEN  = 2'd1,
    TK_CLOSE = 2'd2,
    TK_ERROR = 2'd3
  } token_kind_e;

  typedef enum logic [6:0] {
    ST_INIT    = 7'b0000001,
    ST_ID      = 7'b0000010,
    ST_INT     = 7'b0000100,
    ST_FLOAT   = 7'b0001000,
    ST_COMMENT = 7'b0010000,
    ST_STRING  = 7'b0100000,
    ST_ERROR   = 7'b1000000
  } lex_state_e;

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] stop;
    logic        last;
  } token_t;

  localparam token_t TOKEN_NONE = '{kind: TK_TEXT, start: 16'd0, stop: 16'd0, last: 1'b0};

  function automatic logic dec_digit(logic [7:0] c);
    return (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
  endfunction

  function automatic logic name_lead(logic [7:0] c);
    return ((c >= CH_UC_LO) && (c <= CH_UC_HI)) ||
           ((c >= CH_LC_LO) && (c <= CH_LC_HI)) || (c == CH_DASH);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic paren_char(logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic word_break(logic [7:0] c);
    return paren_char(c) || (c == CH_SEMI) || is_space(c);
  endfunction

  function automatic token_t paren_token(logic [7:0] c);
    token_t t;
    t = TOKEN_NONE;
    t.kind = (c == CH_LPAREN) ? TK_OPEN : TK_CLOSE;
    return t;
  endfunction

endpackage

/* rtl/sexpr_lexer.sv */
// S-expression lexer. Source bytes enter one per transfer on the input channel and
// tokens leave on the output channel: text tokens (identifiers, integers, floats and
// strings) as start position and position just past the end, with a string's closing
// quote included, plus open and close parenthesis tokens and a single error token at
// the first invalid character, after which the block stays silent until reset. A zero
// byte is ignored and does not advance the position; positions wrap at POS_BITS bits
// and the ports show their low 16 bits. last_result marks the final token a byte
// caused. The block takes one byte per clock unless the held byte waits for buffer
// room. A byte passes an input register, the lexer step, and a two-entry output
// buffer; its tokens are registered into the buffer when the lexer step fires. A
// byte that yields both a text token and a parenthesis fills both entries, and the
// output shows them one after the other; the lexer step waits only while the output
// buffer lacks room for the tokens of the byte it holds.
module sexpr_lexer
  import sxl_pkg::*;
#(
  parameter int POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_end_o,
  output logic        last_result_o
);

  // Low 16 bits of a position, zero extended when positions are narrower.
  function automatic logic [15:0] pos16(logic [POS_BITS-1:0] p);
    logic [POS_BITS+15:0] w;
    w = {16'd0, p};
    return w[15:0];
  endfunction

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q, s1_byte_d;
  logic       in_xfer, s1_fire;

  // Lexer state.
  lex_state_e          state_q, state_d, state_nxt;
  logic [POS_BITS-1:0] begin_q, begin_d, begin_nxt;
  logic [POS_BITS-1:0] pos_q, pos_d, pos_inc;

  // Output buffer: slot 0 is the head.
  token_t     slot_q [2];
  token_t     slot_d [2];
  logic [1:0] count_q, count_d;
  logic [1:0] cnt_pop, room;
  logic       out_xfer;

  // Tokens of the byte in the input register.
  logic [1:0] n_tok;
  token_t     tok0, tok1;
  logic [7:0] c;

  assign c       = s1_byte_q;
  assign pos_inc = pos_q + POS_BITS'(1);

  // One lexer step on the held byte. At most two tokens come out: a text token
  // closed by a breaker, followed by the parenthesis that closed it.
  always_comb begin
    n_tok     = 2'd0;
    tok0      = TOKEN_NONE;
    tok1      = TOKEN_NONE;
    state_nxt = state_q;
    begin_nxt = begin_q;
    unique case (state_q) inside
      ST_INIT: begin
        if (paren_char(c)) begin
          n_tok = 2'd1;
          tok0  = paren_token(c);
        end else if (dec_digit(c)) begin
          state_nxt = ST_INT;
          begin_nxt = pos_q;
        end else if (name_lead(c)) begin
          state_nxt = ST_ID;
          begin_nxt = pos_q;
        end else if (c == CH_QUOTE) begin
          state_nxt = ST_STRING;
          begin_nxt = pos_q;
        end else if (c == CH_SEMI) begin
          state_nxt = ST_COMMENT;
        end else if (!is_space(c)) begin
          n_tok     = 2'd1;
          tok0.kind = TK_ERROR;
          state_nxt = ST_ERROR;
        end
      end
      ST_ID, ST_INT, ST_FLOAT: begin
        if ((state_q == ST_INT) && (c == CH_DOT)) begin
          state_nxt = ST_FLOAT;
        end else if ((state_q == ST_ID) ? (name_lead(c) || dec_digit(c)) : dec_digit(c)) begin
          state_nxt = state_q;
        end else if (word_break(c)) begin
          tok0.kind  = TK_TEXT;
          tok0.start = pos16(begin_q);
          tok0.stop  = pos16(pos_q);
          if (paren_char(c)) begin
            n_tok = 2'd2;
            tok1  = paren_token(c);
          end else begin
            n_tok = 2'd1;
          end
          state_nxt = (c == CH_SEMI) ? ST_COMMENT : ST_INIT;
        end else begin
          n_tok     = 2'd1;
          tok0.kind = TK_ERROR;
          state_nxt = ST_ERROR;
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          n_tok      = 2'd1;
          tok0.kind  = TK_TEXT;
          tok0.start = pos16(begin_q);
          tok0.stop  = pos16(pos_inc);
          state_nxt  = ST_INIT;
        end
      end
      ST_COMMENT: begin
        if (c == CH_LF) begin
          state_nxt = ST_INIT;
        end
      end
      ST_ERROR: begin
        state_nxt = ST_ERROR;
      end
      default: begin
        state_nxt = ST_ERROR;
      end
    endcase
    // A zero byte leaves everything as it is.
    if (c == CH_NUL) begin
      n_tok     = 2'd0;
      state_nxt = state_q;
      begin_nxt = begin_q;
    end
    if (n_tok == 2'd1) begin
      tok0.last = 1'b1;
    end
    if (n_tok == 2'd2) begin
      tok1.last = 1'b1;
    end
  end

  // Handshakes. The lexer step fires when the buffer, after this cycle's
  // output transfer, has room for all tokens of the held byte.
  assign out_valid_o = (count_q != 2'd0);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign cnt_pop     = count_q - {1'b0, out_xfer};
  assign room        = 2'd2 - cnt_pop;
  assign s1_fire     = s1_valid_q && (n_tok <= room);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign in_xfer     = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign s1_byte_d  = in_xfer ? in_byte_i : s1_byte_q;

  always_comb begin
    state_d = state_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    if (s1_fire && (c != CH_NUL)) begin
      state_d = state_nxt;
      begin_d = begin_nxt;
      pos_d   = pos_inc;
    end
  end

  // Buffer update: pop shifts slot 1 forward, new tokens append behind what stays.
  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (out_xfer) begin
      slot_d[0] = slot_q[1];
    end
    if (s1_fire && (n_tok != 2'd0)) begin
      slot_d[cnt_pop[0]] = tok0;
    end
    if (s1_fire && (n_tok == 2'd2)) begin
      slot_d[1] = tok1;
    end
    count_d = s1_fire ? (cnt_pop + n_tok) : cnt_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= ST_INIT;
      begin_q    <= '0;
      pos_q      <= '0;
      count_q    <= 2'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      state_q    <= state_d;
      begin_q    <= begin_d;
      pos_q      <= pos_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign token_kind_o  = slot_q[0].kind;
  assign token_start_o = slot_q[0].start;
  assign token_end_o   = slot_q[0].stop;
  assign last_result_o = slot_q[0].last;

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("output buffer overfilled");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ERROR |=> state_q == ST_ERROR) else $error("left error state");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (slot_q[0].kind == TK_ERROR) |-> slot_q[0].last)
    else $error("error token not final");

  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (n_tok == 2'd2) |->
      (tok0.kind == TK_TEXT) && !tok0.last && tok1.last && (tok1.kind != TK_TEXT))
    else $error("bad token pair");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && (count_q != 2'd0)) else $error("stall without cause");
`endif

endmodule

/* bench/lexer_token_check.sv */
`timescale 1ns / 1ps

// Watches both channels of the lexer. Every byte transfer is run through a
// local copy of the lexer, and the tokens it gives are queued; every token
// transfer is compared against the oldest queued token.
module lexer_token_check
  import sxl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  token_kind_o,
  input  logic [15:0] token_start_o,
  input  logic [15:0] token_end_o,
  input  logic        last_result_o,
  output int          fail_count_o,
  output int          tokens_due_o
);

  lex_state_e  lex_st;
  logic [15:0] word_begin;
  logic [15:0] next_pos;
  token_t      tokens_due[$];
  int          errors = 0;

  assign fail_count_o = errors;

  function automatic bit num_char(logic [7:0] c);
    return (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
  endfunction

  function automatic bit name_head(logic [7:0] c);
    return ((c >= CH_UC_LO) && (c <= CH_UC_HI)) ||
           ((c >= CH_LC_LO) && (c <= CH_LC_HI)) || (c == CH_DASH);
  endfunction

  function automatic bit blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic bit word_stop(logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SEMI) || blank(c);
  endfunction

  function automatic token_t make_tok(token_kind_e kind, logic [15:0] s, logic [15:0] e);
    token_t t;
    t.kind  = kind;
    t.start = s;
    t.stop  = e;
    t.last  = 1'b0;
    return t;
  endfunction

  task automatic mismatch(input string msg);
    $display("token check: %s", msg);
    errors++;
  endtask

  // Advances the local lexer by one byte and queues the tokens it gives.
  task automatic lex_one_byte(input logic [7:0] c);
    token_t      made [2];
    int          n;
    logic [15:0] pos;
    n   = 0;
    pos = next_pos;
    if (c == CH_NUL) return;
    next_pos = next_pos + 16'd1;
    case (lex_st)
      ST_INIT: begin
        if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
          made[n] = make_tok((c == CH_LPAREN) ? TK_OPEN : TK_CLOSE, '0, '0);
          n++;
        end else if (num_char(c)) begin
          lex_st = ST_INT;
          word_begin = pos;
        end else if (name_head(c)) begin
          lex_st = ST_ID;
          word_begin = pos;
        end else if (c == CH_QUOTE) begin
          lex_st = ST_STRING;
          word_begin = pos;
        end else if (c == CH_SEMI) begin
          lex_st = ST_COMMENT;
        end else if (!blank(c)) begin
          made[n] = make_tok(TK_ERROR, '0, '0);
          n++;
          lex_st = ST_ERROR;
        end
      end
      ST_ID, ST_INT, ST_FLOAT: begin
        if ((lex_st == ST_INT) && (c == CH_DOT)) begin
          lex_st = ST_FLOAT;
        end else if ((lex_st == ST_ID) ? (name_head(c) || num_char(c)) : num_char(c)) begin
          // The word goes on.
        end else if (word_stop(c)) begin
          made[n] = make_tok(TK_TEXT, word_begin, pos);
          n++;
          if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
            made[n] = make_tok((c == CH_LPAREN) ? TK_OPEN : TK_CLOSE, '0, '0);
            n++;
          end
          lex_st = (c == CH_SEMI) ? ST_COMMENT : ST_INIT;
        end else begin
          made[n] = make_tok(TK_ERROR, '0, '0);
          n++;
          lex_st = ST_ERROR;
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          made[n] = make_tok(TK_TEXT, word_begin, pos + 16'd1);
          n++;
          lex_st = ST_INIT;
        end
      end
      ST_COMMENT: begin
        if (c == CH_LF) lex_st = ST_INIT;
      end
      default: begin
        lex_st = ST_ERROR;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) made[i].last = 1'b1;
      tokens_due.push_back(made[i]);
    end
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      mismatch($sformatf("token with none expected: kind %0d start %h end %h",
                         token_kind_o, token_start_o, token_end_o));
    end else begin
      want = tokens_due.pop_front();
      if (token_kind_o !== want.kind)
        mismatch($sformatf("kind: expected %0d, got %0d", want.kind, token_kind_o));
      if (token_start_o !== want.start)
        mismatch($sformatf("start: expected %h, got %h", want.start, token_start_o));
      if (token_end_o !== want.stop)
        mismatch($sformatf("end: expected %h, got %h", want.stop, token_end_o));
      if (last_result_o !== want.last)
        mismatch($sformatf("last: expected %b, got %b", want.last, last_result_o));
    end
  endtask

  // Tokens are checked before the byte of the same edge is lexed, since a
  // token can never come out in the cycle its byte goes in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_st     = ST_INIT;
      word_begin = '0;
      next_pos   = '0;
      tokens_due.delete();
      tokens_due_o <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_token();
      if (in_valid_i && !in_stall_o) lex_one_byte(in_byte_i);
      tokens_due_o <= tokens_due.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

// Top of the lexer bench. It makes the byte stream, the stalls on the token
// side and the verdict; the checker beside the block does all prediction.
module tb_top;
  import sxl_pkg::*;

  // Cycles in a row with no transfer on either channel before the run is
  // given up.
  localparam int          IDLE_LIMIT   = 2000;
  // Nonzero bytes to feed before the closing part of the run.
  localparam int          RANDOM_BYTES = 1200;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  token_kind_o;
  logic [15:0] token_start_o;
  logic [15:0] token_end_o;
  logic        last_result_o;

  int          fail_count;
  int          tokens_due;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int          stall_left  = 0;
  int          idle_cycles = 0;
  int          bytes_fed   = 0;
  int          next_shift  = 0;

  sexpr_lexer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_end_o   (token_end_o),
    .last_result_o (last_result_o)
  );

  lexer_token_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_end_o   (token_end_o),
    .last_result_o (last_result_o),
    .fail_count_o  (fail_count),
    .tokens_due_o  (tokens_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Token-side stalls come in bursts whose length is drawn at random. A burst starts
  // with a chance of stall_pct percent per free cycle; at zero no new burst
  // starts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ((stall_pct != 0) && ($urandom_range(0, 99) < stall_pct)) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // One byte transfer. A gap with valid low may come first; the byte then
  // stays put until the block takes it. Only nonzero bytes are counted, just
  // as only they move the position in the block.
  task automatic send_byte(input logic [7:0] b);
    if ((gap_pct != 0) && ($urandom_range(0, 99) < gap_pct)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (b != CH_NUL) begin
      bytes_fed++;
    end
  endtask

  // A source character, now and then preceded by a zero byte that the lexer
  // must skip without any effect on its state or position.
  task automatic put_char(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) send_byte(CH_NUL);
    send_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_name_head();
    int k;
    k = $urandom_range(0, 52);
    if (k < 26) return 8'(CH_UC_LO + k);
    if (k < 52) return 8'(CH_LC_LO + k - 26);
    return CH_DASH;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_DIG_LO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_name_tail();
    if ($urandom_range(0, 4) == 0) return pick_digit();
    return pick_name_head();
  endfunction

  function automatic logic [7:0] pick_breaker();
    case ($urandom_range(0, 6))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_LF;
      4:       return CH_LPAREN;
      5:       return CH_RPAREN;
      default: return CH_SEMI;
    endcase
  endfunction

  // Any nonzero byte except the one given; the upper half of the byte range
  // shows up through here inside strings and comments.
  function automatic logic [7:0] any_but(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == x);
    return b;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 35;
    endcase
  endfunction

  task automatic comment_body();
    repeat ($urandom_range(0, 10)) put_char(any_but(CH_LF));
    put_char(CH_LF);
  endtask

  // Closes a word with a breaker. A semicolon opens a comment, which is
  // run to its line end so the lexer is back in its initial state.
  task automatic end_word();
    logic [7:0] b;
    b = pick_breaker();
    put_char(b);
    if (b == CH_SEMI) comment_body();
  endtask

  task automatic name_token();
    put_char(pick_name_head());
    repeat ($urandom_range(0, 6)) put_char(pick_name_tail());
    end_word();
  endtask

  // An integer, or a float when a dot follows the leading digits.
  task automatic number_token();
    repeat ($urandom_range(1, 5)) put_char(pick_digit());
    if ($urandom_range(0, 9) < 4) begin
      put_char(CH_DOT);
      repeat ($urandom_range(0, 3)) put_char(pick_digit());
    end
    end_word();
  endtask

  task automatic string_token();
    put_char(CH_QUOTE);
    repeat ($urandom_range(0, 8)) put_char(any_but(CH_QUOTE));
    put_char(CH_QUOTE);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: a skipped zero byte, a parenthesis, a name that ends
    // on a breaker, a float closed by a comment that holds the byte extremes,
    // a name ending in a parenthesis so that one byte gives two tokens, a
    // string with control bytes, an integer ended by a close
    // parenthesis, and the letter and whitespace extremes.
    send_byte(CH_NUL);
    send_text("(zA-9 0.5;");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("\n-(\"");
    send_byte(8'h7F);
    send_byte(8'h01);
    send_text("\"9)\tZa\r");

    // Random part: mostly well-formed words, strings, comments and
    // parentheses with random content, salted with zero bytes. The idling
    // mix on both sides changes every few dozen bytes, and some stretches
    // have no idling at all.
    while (bytes_fed < RANDOM_BYTES) begin
      if (bytes_fed >= next_shift) begin
        next_shift = next_shift + 60;
        gap_pct    = pick_pct();
        stall_pct  = pick_pct();
      end
      case ($urandom_range(0, 9))
        0:       put_char(CH_LPAREN);
        1:       put_char(CH_RPAREN);
        2, 3:    name_token();
        4, 5:    number_token();
        6:       string_token();
        7: begin
          put_char(CH_SEMI);
          comment_body();
        end
        8:       repeat ($urandom_range(1, 3)) put_char(pick_breaker() == CH_SEMI ?
                                                    CH_SPACE : CH_TAB);
        default: send_byte(CH_NUL);
      endcase
    end

    // Closing part, with no idling on either side: a short comment, then
    // words, a string and parentheses back to back.
    gap_pct   = 0;
    stall_pct = 0;
    send_text(" ;");
    repeat (6) send_byte(any_but(CH_LF));
    send_text("\nabc defgh(\"q\" 7.5)x1 ");

    // The first invalid character gives one error token and silences the
    // block for good, so exactly one flavor of it can be shown per run.
    case ($urandom_range(0, 3))
      0:       send_text("#");
      1:       send_text("ab#");
      2:       send_text("1.2.");
      default: send_text("5x");
    endcase
    // Everything after the error is swallowed, zero bytes and all.
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;

    // Drain: wait for every expected token, then keep the clock running so that
    // any stray token still gets caught.
    do @(posedge clk_i); while (tokens_due != 0);
    repeat (8) @(posedge clk_i);
    if ((fail_count == 0) && (tokens_due == 0)) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sxl_pkg.sv
rtl/sexpr_lexer.sv
bench/lexer_token_check.sv
bench/tb_top.sv
